[rtl/core/sltd_pkg.sv]
// Shared codes, defaults and types for the start/length/tail deframer.
// No dependencies; used by sltd_parse and start_length_tail_deframer.
package sltd_pkg;

   localparam int LENGTH_BITS_DEF = 15;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 3;
   localparam int PHASE_W = 3;
   localparam int INDEX_W = 8;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_GOOD      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_START_ERR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LEN_ERR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TAIL_ERR  = 3'd4;

   // register indexes
   localparam logic [INDEX_W-1:0] REG_START_FIRST  = 8'd0;
   localparam logic [INDEX_W-1:0] REG_START_SECOND = 8'd1;
   localparam logic [INDEX_W-1:0] REG_END_FIRST    = 8'd2;
   localparam logic [INDEX_W-1:0] REG_END_SECOND   = 8'd3;

   localparam logic [BYTE_W-1:0] START_FIRST_RST  = 8'hAA;
   localparam logic [BYTE_W-1:0] START_SECOND_RST = 8'h55;
   localparam logic [BYTE_W-1:0] END_FIRST_RST    = 8'h55;
   localparam logic [BYTE_W-1:0] END_SECOND_RST   = 8'hAA;

   typedef struct packed {
      logic [BYTE_W-1:0] start_first;
      logic [BYTE_W-1:0] start_second;
      logic [BYTE_W-1:0] end_first;
      logic [BYTE_W-1:0] end_second;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_last;
   } result_type;

endpackage

[rtl/core/sltd_parse.sv]
// Frame state machine of the deframer: phase, length and tail tracking.
// Produces at most one result per accepted request. Depends on sltd_pkg.
module sltd_parse #(
   parameter int LENGTH_BITS = sltd_pkg::LENGTH_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [sltd_pkg::BYTE_W-1:0] rx_byte,
   input  sltd_pkg::cfg_type          cfg,
   output sltd_pkg::result_type       result
);
   import sltd_pkg::*;

   localparam logic [PHASE_W-1:0] PH_START1  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_START2  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEN_LO  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_LEN_HI  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;
   localparam logic [PHASE_W-1:0] PH_END1    = 3'd5;
   localparam logic [PHASE_W-1:0] PH_END2    = 3'd6;
   localparam logic [PHASE_W-1:0] PH_CLOSED  = 3'd7;

   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [BYTE_W-1:0]      length_low_ff, length_low_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic                   tail_first_ok_ff, tail_first_ok_in;

   logic [2*BYTE_W-1:0]    length_full;
   logic                   length_over;
   logic [LENGTH_BITS-1:0] bytes_dec;

   assign length_full = {rx_byte, length_low_ff};
   assign length_over = |(length_full >> LENGTH_BITS);
   assign bytes_dec   = (bytes_left_ff != '0) ? bytes_left_ff - 1'b1 : bytes_left_ff;

   always_comb begin
      phase_in            = phase_ff;
      length_low_in       = length_low_ff;
      bytes_left_in       = bytes_left_ff;
      tail_first_ok_in    = tail_first_ok_ff;
      result.valid        = 1'b0;
      result.kind         = KIND_PAYLOAD;
      result.payload_byte = '0;
      result.frame_last   = 1'b0;
      case (phase_ff)
         PH_START1: begin
            if (rx_byte != cfg.start_first) begin
               phase_in          = PH_CLOSED;
               result.valid      = 1'b1;
               result.kind       = KIND_START_ERR;
               result.frame_last = 1'b1;
            end else begin
               phase_in = PH_START2;
            end
         end
         PH_START2: begin
            if (rx_byte != cfg.start_second) begin
               phase_in          = PH_CLOSED;
               result.valid      = 1'b1;
               result.kind       = KIND_START_ERR;
               result.frame_last = 1'b1;
            end else begin
               phase_in = PH_LEN_LO;
            end
         end
         PH_LEN_LO: begin
            length_low_in = rx_byte;
            phase_in      = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            if (length_over) begin
               phase_in          = PH_CLOSED;
               result.valid      = 1'b1;
               result.kind       = KIND_LEN_ERR;
               result.frame_last = 1'b1;
            end else begin
               bytes_left_in = length_full[LENGTH_BITS-1:0];
               phase_in      = (length_full[LENGTH_BITS-1:0] == '0) ? PH_END1 : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            bytes_left_in       = bytes_dec;
            if (bytes_dec == '0) phase_in = PH_END1;
            result.valid        = 1'b1;
            result.kind         = KIND_PAYLOAD;
            result.payload_byte = rx_byte;
         end
         PH_END1: begin
            tail_first_ok_in = (rx_byte == cfg.end_first);
            phase_in         = PH_END2;
         end
         PH_END2: begin
            tail_first_ok_in  = 1'b0;
            result.valid      = 1'b1;
            result.frame_last = 1'b1;
            if (tail_first_ok_ff && rx_byte == cfg.end_second) begin
               phase_in    = PH_START1;
               result.kind = KIND_GOOD;
            end else begin
               phase_in    = PH_CLOSED;
               result.kind = KIND_TAIL_ERR;
            end
         end
         default: begin
            // closed: drop everything until reset
            phase_in = PH_CLOSED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_START1;
         length_low_ff    <= '0;
         bytes_left_ff    <= '0;
         tail_first_ok_ff <= 1'b0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         length_low_ff    <= length_low_in;
         bytes_left_ff    <= bytes_left_in;
         tail_first_ok_ff <= tail_first_ok_in;
      end
   end

`ifndef SYNTHESIS
   // payload phase never holds an empty count
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> bytes_left_ff != '0)
      else $error("payload phase with no bytes left");

   // once closed, stay closed
   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CLOSED |=> phase_ff == PH_CLOSED)
      else $error("left closed phase without reset");

   // nothing comes out of a closed block
   a_closed_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CLOSED |-> !result.valid)
      else $error("result produced while closed");
`endif

endmodule

[rtl/core/start_length_tail_deframer.sv]
// Top level of the start/length/tail deframer: handshakes, registers, result register.
// Depends on sltd_pkg and sltd_parse.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_stall | rsp_kind, rsp_payload_byte, rsp_frame_last
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One request per cycle while req_stall is low; its result, if any, is in the result register the next cycle.
// The state update passes through the combinational phase decoder between the input and result.
// Reset (synchronous) restores default register values and expects a first start byte.
// req_stall rises only while a result is held in the result register and rsp_stall is high.
module start_length_tail_deframer #(
   parameter int LENGTH_BITS = sltd_pkg::LENGTH_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sltd_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sltd_pkg::KIND_W-1:0]  rsp_kind,
   output logic [sltd_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic                         rsp_frame_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sltd_pkg::INDEX_W-1:0] csr_index,
   input  logic [sltd_pkg::BYTE_W-1:0]  csr_wdata
);
   import sltd_pkg::*;

   cfg_type    cfg_ff;
   result_type result;
   logic       accept;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [BYTE_W-1:0] rsp_payload_byte_ff;
   logic              rsp_frame_last_ff;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_first  <= START_FIRST_RST;
         cfg_ff.start_second <= START_SECOND_RST;
         cfg_ff.end_first    <= END_FIRST_RST;
         cfg_ff.end_second   <= END_SECOND_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_START_FIRST:  cfg_ff.start_first  <= csr_wdata;
            REG_START_SECOND: cfg_ff.start_second <= csr_wdata;
            REG_END_FIRST:    cfg_ff.end_first    <= csr_wdata;
            REG_END_SECOND:   cfg_ff.end_second   <= csr_wdata;
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   sltd_parse #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result.valid) begin
         rsp_kind_ff         <= result.kind;
         rsp_payload_byte_ff <= result.payload_byte;
         rsp_frame_last_ff   <= result.frame_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_payload_byte = rsp_payload_byte_ff;
   assign rsp_frame_last   = rsp_frame_last_ff;

`ifndef SYNTHESIS
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != KIND_PAYLOAD |-> rsp_frame_last_ff)
      else $error("status result without frame_last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != KIND_PAYLOAD |-> rsp_payload_byte_ff == '0)
      else $error("status result carries payload data");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_kind_ff == KIND_PAYLOAD || rsp_kind_ff == KIND_GOOD ||
                        rsp_kind_ff == KIND_START_ERR || rsp_kind_ff == KIND_LEN_ERR ||
                        rsp_kind_ff == KIND_TAIL_ERR))
      else $error("result kind out of range");

   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> rsp_valid_ff)
      else $error("held result lost while requests stalled");
`endif

endmodule
